>>> hdl/pcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color fade cycler package
// Shared widths, reset values and the fixed palette lookup.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int PCF_TICK_W    = 16;   // delta_ticks and change_ticks
    localparam int PCF_TIMER_W   = 17;   // phase timer
    localparam int PCF_CHAN_W    = 8;    // one color channel
    localparam int PCF_RGB_W     = 24;   // packed RGB word
    localparam int PCF_PROD_W    = 24;   // channel delta times timer, below 255 * 65536
    localparam int PCF_STEP_W    = 3;    // divide step counter, one per quotient bit
    localparam int PCF_IDX_MAX_W = 8;    // widest palette index

    typedef logic [PCF_TICK_W-1:0]  t_ticks;
    typedef logic [PCF_TIMER_W-1:0] t_timer;
    typedef logic [PCF_CHAN_W-1:0]  t_chan;
    typedef logic [PCF_RGB_W-1:0]   t_rgb;

    localparam t_ticks PCF_CHANGE_RESET = 16'd1100;
    localparam t_timer PCF_TIMER_RESET  = 17'd1100;

    localparam t_rgb PCF_GRAY   = 24'h4A4A4A;
    localparam t_rgb PCF_HUE_0  = 24'hC2751D;
    localparam t_rgb PCF_HUE_1  = 24'h4DC456;
    localparam t_rgb PCF_HUE_2  = 24'h4D77C4;
    localparam t_rgb PCF_HUE_3  = 24'h934DC4;

    // Odd entries are gray, even entries walk the four hues.
    function automatic t_rgb pcf_palette_entry(input logic [PCF_IDX_MAX_W-1:0] k);
        t_rgb c;
        if (k[0]) begin
            c = PCF_GRAY;
        end else begin
            case (k[2:1])
                2'd0:    c = PCF_HUE_0;
                2'd1:    c = PCF_HUE_1;
                2'd2:    c = PCF_HUE_2;
                default: c = PCF_HUE_3;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pcf_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color fade cycler channels
// Valid/ready interfaces for the tick input and the RGB result.
// ----------------------------------------------------------------------------
interface pcf_in_if
    import pcf_pkg::*;
;
    logic   valid;
    logic   ready;
    t_ticks delta_ticks;

    modport source (output valid, output delta_ticks, input ready);
    modport sink   (input valid, input delta_ticks, output ready);
endinterface

interface pcf_out_if
    import pcf_pkg::*;
;
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

>>> hdl/palette_color_fade_cycler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color fade cycler core
// Advances a fade timer by elapsed ticks and returns the faded RGB color.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch carries one transaction per update: the ticks elapsed since the
//   previous update. o_out_ch returns one transaction per update: the current
//   red, green and blue channels, faded linearly from the previous palette
//   color to the next one. i_cfg_we/i_cfg_wdata set the fade period
//   (change_ticks, 0 acts as 1); write it only while the block is idle.
// Sequence:
//   An accepted update runs the period check, then the timer clamp, then per
//   channel a multiply and a restoring divide, one step per quotient bit, on
//   a single shared subtractor, and then hands the result over to the output
//   register. i_in_ch.ready is high only in the idle state, so a new update
//   is taken only once the last one has been handed over.
// Reset (synchronous, active low):
//   Period and timer go to 1100, index and both colors to zero, so the first
//   update steps to palette entry 1 at once. No result is pending after reset.
// Stall:
//   A result waits in the output register while the sink holds ready low; the
//   next update is still accepted and worked on, and it waits in its final
//   state until the output register frees up.
// ----------------------------------------------------------------------------
module palette_color_fade_cycler_core
    import pcf_pkg::*;
#(
    parameter int PALETTE_SIZE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    pcf_in_if.sink           i_in_ch,
    pcf_out_if.source        o_out_ch
);

    localparam int IDX_W = $clog2(PALETTE_SIZE);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for an update
    localparam logic [2:0] S_ADV  = 3'd1;  // period check and palette step
    localparam logic [2:0] S_CLP  = 3'd2;  // saturate timer at the period
    localparam logic [2:0] S_MUL  = 3'd3;  // channel delta times timer
    localparam logic [2:0] S_DIV  = 3'd4;  // one quotient bit per cycle
    localparam logic [2:0] S_FIN  = 3'd5;  // hand result to output register

    // Channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Control state
    logic [2:0]            r_state, n_state;
    logic [1:0]            r_ch, n_ch;
    logic [PCF_STEP_W-1:0] r_step, n_step;
    logic                  r_out_valid, n_out_valid;

    // Architectural state
    t_ticks                r_change, n_change;
    t_timer                r_timer, n_timer;
    logic [IDX_W-1:0]      r_idx, n_idx;
    t_rgb                  r_prev, n_prev;
    t_rgb                  r_next, n_next;

    // Working registers
    t_ticks                r_period, n_period;
    logic [15:0]           r_rem, n_rem;
    t_chan                 r_low, n_low;
    t_chan                 r_quo, n_quo;
    t_chan                 r_base, n_base;
    logic                  r_neg, n_neg;
    t_rgb                  r_res, n_res;
    t_chan                 r_red, n_red;
    t_chan                 r_green, n_green;
    t_chan                 r_blue, n_blue;

    // Shared subtract/compare unit
    logic [PCF_TIMER_W-1:0] w_sub_a;
    logic [PCF_TIMER_W:0]   w_sub;
    logic                   w_ge;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic [IDX_W-1:0]       w_idx_inc;
    t_chan                  w_a;
    t_chan                  w_b;
    t_chan                  w_diff;
    logic [PCF_PROD_W-1:0]  w_prod;
    logic [PCF_TIMER_W-1:0] w_rem_sh;
    t_chan                  w_q;
    t_chan                  w_chan_res;

    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign w_in_acc       = i_in_ch.valid && (r_state == S_IDLE);
    assign w_out_free     = !r_out_valid || o_out_ch.ready;

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.red   = r_red;
    assign o_out_ch.green = r_green;
    assign o_out_ch.blue  = r_blue;

    // Wrap the palette index at the end of the palette
    assign w_idx_inc = (r_idx == IDX_W'(PALETTE_SIZE - 1)) ? '0 : r_idx + 1'b1;

    // One subtractor serves the period check, the clamp and every divide step
    assign w_rem_sh = {r_rem, r_low[PCF_CHAN_W-1]};
    always_comb begin
        case (r_state)
            S_DIV:   w_sub_a = w_rem_sh;
            default: w_sub_a = r_timer;
        endcase
    end
    assign w_sub = {1'b0, w_sub_a} - {2'b00, r_period};
    assign w_ge  = ~w_sub[PCF_TIMER_W];

    // Pick the channel pair and take the magnitude of its difference
    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_a = r_prev[23:16];
                w_b = r_next[23:16];
            end
            CH_GREEN: begin
                w_a = r_prev[15:8];
                w_b = r_next[15:8];
            end
            default: begin
                w_a = r_prev[7:0];
                w_b = r_next[7:0];
            end
        endcase
    end
    assign w_diff = (w_b >= w_a) ? (w_b - w_a) : (w_a - w_b);
    assign w_prod = PCF_PROD_W'(w_diff) * PCF_PROD_W'(r_timer);

    // Final quotient bit joins the rest; apply it toward the next color
    assign w_q        = {r_quo[PCF_CHAN_W-2:0], w_ge};
    assign w_chan_res = r_neg ? (r_base - w_q) : (r_base + w_q);

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_change    = r_change;
        n_timer     = r_timer;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_next      = r_next;
        n_period    = r_period;
        n_rem       = r_rem;
        n_low       = r_low;
        n_quo       = r_quo;
        n_base      = r_base;
        n_neg       = r_neg;
        n_res       = r_res;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;

        if (i_cfg_we) begin
            n_change = i_cfg_wdata;
        end

        // Drop the valid once the sink takes the transaction
        if (r_out_valid && o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // Timer stays at or below the period, so the sum fits 17 bits
                    n_timer  = r_timer + PCF_TIMER_W'(i_in_ch.delta_ticks);
                    n_period = (r_change == '0) ? t_ticks'(1) : r_change;
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                if (w_ge) begin
                    n_timer = w_sub[PCF_TIMER_W-1:0];
                    n_prev  = pcf_palette_entry(PCF_IDX_MAX_W'(r_idx));
                    n_next  = pcf_palette_entry(PCF_IDX_MAX_W'(w_idx_inc));
                    n_idx   = w_idx_inc;
                end
                n_state = S_CLP;
            end
            S_CLP: begin
                if (w_ge) begin
                    n_timer = PCF_TIMER_W'(r_period);
                end
                n_ch    = CH_RED;
                n_state = S_MUL;
            end
            S_MUL: begin
                // Quotient stays below 256, so the high bits start below the period
                n_rem   = w_prod[23:8];
                n_low   = w_prod[7:0];
                n_quo   = '0;
                n_base  = w_a;
                n_neg   = (w_b < w_a);
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_ge ? w_sub[15:0] : w_rem_sh[15:0];
                n_low  = {r_low[PCF_CHAN_W-2:0], 1'b0};
                n_quo  = w_q;
                n_step = r_step + 1'b1;
                if (r_step == PCF_STEP_W'(PCF_CHAN_W - 1)) begin
                    case (r_ch)
                        CH_RED:   n_res[23:16] = w_chan_res;
                        CH_GREEN: n_res[15:8]  = w_chan_res;
                        default:  n_res[7:0]   = w_chan_res;
                    endcase
                    if (r_ch == CH_BLUE) begin
                        n_state = S_FIN;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_FIN: begin
                // Hold here while an earlier result is still waiting
                if (w_out_free) begin
                    n_red       = r_res[23:16];
                    n_green     = r_res[15:8];
                    n_blue      = r_res[7:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= CH_RED;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_change    <= PCF_CHANGE_RESET;
            r_timer     <= PCF_TIMER_RESET;
            r_idx       <= '0;
            r_prev      <= '0;
            r_next      <= '0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_change    <= n_change;
            r_timer     <= n_timer;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
            r_next      <= n_next;
        end
    end

    // Payload and working registers need no reset
    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_rem    <= n_rem;
        r_low    <= n_low;
        r_quo    <= n_quo;
        r_base   <= n_base;
        r_neg    <= n_neg;
        r_res    <= n_res;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
    end

endmodule
`default_nettype wire

>>> hdl/pcf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color fade cycler checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module pcf_checker
    import pcf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rgb i_out_rgb
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rgb))
        else $error("stalled result changed or vanished");

    // Go busy right after taking an update
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // A result cannot come out the cycle after an update is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind palette_color_fade_cycler_core pcf_checker u_pcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_rgb   ({o_out_ch.red, o_out_ch.green, o_out_ch.blue})
);
`default_nettype wire

>>> tb/sv/pcf_fade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color fade checker
// Watches the tick and color channels, predicts each faded color and
// compares it with the color the core returns.
// ----------------------------------------------------------------------------
module pcf_fade_checker
    import pcf_pkg::*;
#(
    parameter int PALETTE_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    pcf_in_if           in_ch,
    pcf_out_if          out_ch,
    output int          o_mismatch_count,
    output int          o_colors_pending
);

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_color;

    t_ticks fade_period;
    t_timer fade_timer;
    int     to_index;
    t_rgb   from_rgb;
    t_rgb   to_rgb;
    t_color pending_colors[$];
    int     mismatch_count = 0;

    // Odd entries are gray, even entries walk the four hues.
    function automatic t_rgb palette_color(input int k);
        if (k % 2 != 0) return PCF_GRAY;
        case ((k / 2) % 4)
            0:       return PCF_HUE_0;
            1:       return PCF_HUE_1;
            2:       return PCF_HUE_2;
            default: return PCF_HUE_3;
        endcase
    endfunction

    // Linear blend truncated toward zero, in either direction.
    function automatic t_chan blend(input t_chan a, input t_chan b,
                                    input int unsigned t, input int unsigned p);
        int unsigned span;
        int unsigned q;
        if (b >= a) begin
            span = b - a;
            q    = span * t / p;
            return t_chan'(a + q);
        end
        span = a - b;
        q    = span * t / p;
        return t_chan'(a - q);
    endfunction

    task automatic advance_fade(input t_ticks delta);
        int unsigned period;
        int unsigned t;
        t_color      c;
        period = (fade_period == '0) ? 1 : fade_period;
        t      = (fade_timer + delta) & 32'h1FFFF;
        if (t >= period) begin
            // Expire one period and step to the following palette entry.
            t        = t - period;
            from_rgb = palette_color(to_index);
            to_index = (to_index + 1 >= PALETTE_SIZE) ? 0 : to_index + 1;
            to_rgb   = palette_color(to_index);
            if (t >= period) t = period;
        end
        fade_timer = t_timer'(t);
        c.red      = blend(from_rgb[23:16], to_rgb[23:16], t, period);
        c.green    = blend(from_rgb[15:8],  to_rgb[15:8],  t, period);
        c.blue     = blend(from_rgb[7:0],   to_rgb[7:0],   t, period);
        pending_colors.push_back(c);
    endtask

    function automatic void compare_channel(input string name, input t_chan want,
                                            input t_chan got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_color want;
        if (!i_rst_n) begin
            fade_period = PCF_CHANGE_RESET;
            fade_timer  = PCF_TIMER_RESET;
            to_index    = 0;
            from_rgb    = '0;
            to_rgb      = '0;
            pending_colors.delete();
        end else begin
            if (i_cfg_we) fade_period = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready) advance_fade(in_ch.delta_ticks);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_colors.size() == 0) begin
                    $display("%0t ns: color %0d/%0d/%0d returned with nothing expected",
                             $time, out_ch.red, out_ch.green, out_ch.blue);
                    mismatch_count++;
                end else begin
                    want = pending_colors.pop_front();
                    compare_channel("red",   want.red,   out_ch.red);
                    compare_channel("green", want.green, out_ch.green);
                    compare_channel("blue",  want.blue,  out_ch.blue);
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_colors_pending <= pending_colors.size();
    end

endmodule

>>> tb/sv/tb_palette_color_fade_cycler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color fade cycler core testbench
// Feeds tick counts in bursts under several fade periods, stalls the color
// sink on shifting patterns, and lets the checker compare every color.
// ----------------------------------------------------------------------------
module tb_palette_color_fade_cycler_core;
    import pcf_pkg::*;

    localparam int PALETTE_SIZE    = 8;
    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int MAX_GAP         = 40;
    localparam int MAX_BURST       = 12;
    // Slack to run on once every predicted color has come back.
    localparam int DRAIN_CYCLES    = 40;
    // Longest quiet stretch in a correct run is a sink hold plus one update,
    // well under this limit.
    localparam int IDLE_LIMIT      = 4000;

    // Sink behavior over one stretch of cycles.
    typedef enum int {
        SINK_OPEN,   // always ready
        SINK_COIN,   // ready on a coin toss
        SINK_PULSE,  // short periodic stalls
        SINK_HOLD    // long stalls with short openings
    } t_sink_mode;

    // Kinds of tick counts, most of them shaped around the current period.
    typedef enum int {
        TICK_ZERO,
        TICK_FULL,
        TICK_ANY,
        TICK_SLICE,
        TICK_PERIOD,
        TICK_NEAR,
        TICK_DOUBLE
    } t_tick_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    pcf_in_if  in_ch ();
    pcf_out_if out_ch ();

    int mismatch_count;
    int colors_pending;
    int period_now = PCF_CHANGE_RESET;

    palette_color_fade_cycler_core #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    pcf_fade_checker #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_fade_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .o_mismatch_count(mismatch_count),
        .o_colors_pending(colors_pending)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Pick a tick count. Most land inside or around one period so the fade
    // walks through its middle, expires exactly, or saturates.
    function automatic t_ticks pick_delta();
        int         r;
        int         v;
        t_tick_kind kind;
        r = $urandom_range(0, 15);
        if (r == 0)       kind = TICK_ZERO;
        else if (r == 1)  kind = TICK_FULL;
        else if (r <= 3)  kind = TICK_ANY;
        else if (r <= 10) kind = TICK_SLICE;
        else if (r <= 12) kind = TICK_PERIOD;
        else if (r <= 14) kind = TICK_NEAR;
        else              kind = TICK_DOUBLE;
        case (kind)
            TICK_ZERO:   v = 0;
            TICK_FULL:   v = 65535;
            TICK_ANY:    v = $urandom_range(0, 65535);
            TICK_SLICE:  v = $urandom_range(0, period_now / 4);
            TICK_PERIOD: v = period_now;
            TICK_NEAR:   v = period_now + $urandom_range(0, 2) - 1;
            default:     v = 2 * period_now;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return t_ticks'(v);
    endfunction

    // Present one tick count and hold it until the core takes it.
    task automatic send_tick(input t_ticks d);
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.delta_ticks <= d;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid for a few cycles; scramble the data meanwhile.
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_ch.valid       <= 1'b0;
            in_ch.delta_ticks <= t_ticks'($urandom_range(0, 65535));
        end
    endtask

    // Stop sending and wait until every predicted color has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (colors_pending != 0) @(negedge i_clk);
    endtask

    // Write the fade period while the core is idle.
    task automatic write_period(input t_ticks value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        period_now  = (value == '0) ? 1 : value;
    endtask

    // Send random tick counts in bursts, with or without gaps between them.
    task automatic send_bursts(input int count, input bit gappy);
        int burst_left;
        int n;
        burst_left = 0;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                if (gappy && n != 0) idle_sender($urandom_range(1, MAX_GAP));
                burst_left = $urandom_range(1, MAX_BURST);
            end
            send_tick(pick_delta());
            burst_left--;
        end
    endtask

    function automatic t_ticks pick_period(input int phase);
        int r;
        if (phase == 0) return 16'd1;
        if (phase == 1) return 16'hFFFF;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r <= 3) return t_ticks'($urandom_range(2, 16));
        if (r <= 7) return t_ticks'($urandom_range(17, 3000));
        return t_ticks'($urandom_range(3001, 65534));
    endfunction

    // Color sink: switch between stall patterns after each stretch of random length.
    initial begin : sink_stall
        int         stretch;
        int         k;
        t_sink_mode mode;
        out_ch.ready = 1'b0;
        forever begin
            stretch = $urandom_range(40, 400);
            mode    = t_sink_mode'($urandom_range(0, 3));
            for (k = 0; k < stretch; k++) begin
                @(negedge i_clk);
                case (mode)
                    SINK_OPEN:  out_ch.ready <= 1'b1;
                    SINK_COIN:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PULSE: out_ch.ready <= (k % 11) >= 4;
                    default:    out_ch.ready <= (k % 64) < 6;
                endcase
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.delta_ticks = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset period: the first update expires a period right away.
        send_tick(16'd0);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd549);
        send_tick(16'd550);
        send_tick(16'd1099);
        // Large jumps saturate the timer: the color lands exactly on next.
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd0);

        // Zero period acts as a period of one.
        write_period(16'd0);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_tick(16'd0);

        // Longest period; leave the timer far along for the next step.
        write_period(16'hFFFF);
        send_tick(16'd32768);
        send_tick(16'd32767);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_tick(16'd40000);

        // Period lowered mid-fade: the timer must clamp at the new period.
        write_period(16'd7);
        send_tick(16'd0);
        send_tick(16'd3);
        send_tick(16'hFFFF);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_period(pick_period(phase));
            send_bursts(ITEMS_PER_PHASE, $urandom_range(0, 3) != 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
